// ===== sv/stereo_multitap_reverb_macros.svh =====
// Assertion macros for the stereo multitap reverb RTL.
`ifndef STEREO_MULTITAP_REVERB_MACROS_SVH
`define STEREO_MULTITAP_REVERB_MACROS_SVH

// Condition holds at every clock edge out of reset.
`define SMR_ASSERT_HOLD(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define SMR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle.
`define SMR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/smr_pkg.sv =====
// Shared types and constants of the stereo multitap reverb.
package smr_pkg;

  localparam int SAMPLE_BITS = 24;

  // Configuration port
  localparam int CFG_IW = 3;
  localparam int CFG_DW = 64;

  localparam logic [CFG_IW-1:0] REG_TAP_DELAYS    = 3'd0;
  localparam logic [CFG_IW-1:0] REG_TAP_GAINS     = 3'd1;
  localparam logic [CFG_IW-1:0] REG_FILTER_ALPHA  = 3'd2;
  localparam logic [CFG_IW-1:0] REG_DAMP_COEF     = 3'd3;
  localparam logic [CFG_IW-1:0] REG_DECAY_GAIN    = 3'd4;
  localparam logic [CFG_IW-1:0] REG_MIX_GAIN      = 3'd5;
  localparam logic [CFG_IW-1:0] REG_BYPASS_TARGET = 3'd6;
  localparam logic [CFG_IW-1:0] REG_BYPASS_SMOOTH = 3'd7;

  localparam int COEF_W = 17;
  localparam int DAMP_W = 16;

  localparam logic [COEF_W-1:0] RST_ALPHA  = 17'd7430;
  localparam logic [DAMP_W-1:0] RST_DAMP   = 16'd26214;
  localparam logic [COEF_W-1:0] RST_DECAY  = 17'd32768;
  localparam logic [COEF_W-1:0] RST_MIX    = 17'd19661;
  localparam logic [COEF_W-1:0] RST_TARGET = 17'd0;
  localparam logic [COEF_W-1:0] RST_SMOOTH = 17'd655;

  // Tap fields packed four to a 64-bit register
  localparam int TAP_FIELDS = 4;
  localparam int TAP_FW     = 16;
  localparam int TAP_IW     = 2;

  localparam int ONE_Q16   = 65536;
  localparam int LEVEL_MAX = 131071;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] in_left;
    logic signed [SAMPLE_BITS-1:0] in_right;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] out_left;
    logic signed [SAMPLE_BITS-1:0] out_right;
  } out_t;

endpackage

// ===== sv/smr_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module smr_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/stereo_multitap_reverb.sv =====
// Stereo multitap early-reflection reverb: sequencer, shared multiplier and ring store.
//
// Usage
//  - Input channel (in_valid_i / in_ready_o / in_data_i): one stereo sample pair per
//    request. Both samples go into the ring store on the accepting edge.
//  - Output channel (out_valid_o / out_ready_i / out_data_o): one saturated stereo pair
//    per input request, in order.
//  - Config port (cfg_we_i / cfg_idx_i / cfg_data_i): write-only, one register per
//    edge; write only while no request is in flight.
//  - Sequence: level update and tap reads, then per channel the filter, damping,
//    decay, mix and bypass steps; the right channel loads the output register.
//    TAP_COUNT above four counts as four. All arithmetic runs through a single 32x18
//    multiplier under the state sequencer, one product per cycle unless an output
//    stall holds it: two products per tap, seven per channel, one for the bypass level.
//  - in_ready_o is high only while the sequencer is idle.
//  - The output register holds a finished pair while the next request is worked on;
//    if the receiver still stalls when the next pair is done, the sequencer waits.
//  - Reset: registers return to their defaults, filters and bypass level clear, and a
//    fill count stands in for clearing the ring, so unwritten entries read as zero.
//    No clearing pass: the block is ready as soon as reset is released.
module stereo_multitap_reverb #(
  parameter int RING_DEPTH = 65536,
  parameter int TAP_COUNT  = 4
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  smr_pkg::in_t                    in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output smr_pkg::out_t                   out_data_o,
  input  logic                            cfg_we_i,
  input  logic [smr_pkg::CFG_IW-1:0]      cfg_idx_i,
  input  logic [smr_pkg::CFG_DW-1:0]      cfg_data_i
);

`include "stereo_multitap_reverb_macros.svh"

  localparam int SB     = smr_pkg::SAMPLE_BITS;
  localparam int AW     = $clog2(RING_DEPTH);
  localparam int FILL_W = $clog2(RING_DEPTH + 1);
  localparam int TAPS_USED = (TAP_COUNT < smr_pkg::TAP_FIELDS) ? TAP_COUNT
                                                                : smr_pkg::TAP_FIELDS;
  // compare-subtract steps to fold a 16-bit delay into the ring
  localparam int MOD_STEPS = (RING_DEPTH >= 65536) ? 0
                           : $clog2((65536 + RING_DEPTH - 1) / RING_DEPTH);

  localparam int ER_W   = SB + 2;   // early reflection
  localparam int ERA_W  = SB + 18;  // tap accumulator
  localparam int LP_W   = SB + 3;   // filter states
  localparam int WET_W  = SB + 5;
  localparam int MIX_W  = SB + 7;
  localparam int MA_W   = SB + 8;   // multiplier A operand
  localparam int MB_W   = 18;       // multiplier B operand
  localparam int PROD_W = MA_W + MB_W;
  localparam int ACC_W  = PROD_W + 2;

  localparam logic [smr_pkg::TAP_IW-1:0] TAP_LAST = smr_pkg::TAP_IW'(TAPS_USED - 1);

  localparam logic signed [ACC_W-1:0] WIDE_MAX = (ACC_W'(1) << (SB + 2)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] WIDE_MIN = ~WIDE_MAX;
  localparam logic signed [ACC_W-1:0] SMP_MAX  = (ACC_W'(1) << (SB - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] SMP_MIN  = ~SMP_MAX;
  localparam logic signed [ACC_W-1:0] LVL_MAX  = ACC_W'(smr_pkg::LEVEL_MAX);

  // Sequencer states
  localparam int ST_W = 5;
  localparam logic [ST_W-1:0] ST_IDLE     = 5'd0;
  localparam logic [ST_W-1:0] ST_LVL_MUL  = 5'd1;
  localparam logic [ST_W-1:0] ST_LVL_UPD  = 5'd2;
  localparam logic [ST_W-1:0] ST_TAP_L    = 5'd3;
  localparam logic [ST_W-1:0] ST_TAP_R    = 5'd4;
  localparam logic [ST_W-1:0] ST_TAP_END  = 5'd5;
  localparam logic [ST_W-1:0] ST_LP_MUL   = 5'd6;
  localparam logic [ST_W-1:0] ST_LP_UPD   = 5'd7;
  localparam logic [ST_W-1:0] ST_DP_MUL1  = 5'd8;
  localparam logic [ST_W-1:0] ST_DP_MUL2  = 5'd9;
  localparam logic [ST_W-1:0] ST_DP_UPD   = 5'd10;
  localparam logic [ST_W-1:0] ST_DEC_MUL  = 5'd11;
  localparam logic [ST_W-1:0] ST_WET      = 5'd12;
  localparam logic [ST_W-1:0] ST_MIX_MUL  = 5'd13;
  localparam logic [ST_W-1:0] ST_MIX_UPD  = 5'd14;
  localparam logic [ST_W-1:0] ST_BYP_MUL  = 5'd15;
  localparam logic [ST_W-1:0] ST_OUT      = 5'd16;

  // Delay modulo ring depth, delay below 2^16
  function automatic logic [AW-1:0] ring_mod(input logic [smr_pkg::TAP_FW-1:0] d);
    logic [17:0] r;
    r = {2'b00, d};
    for (int k = MOD_STEPS - 1; k >= 0; k--) begin
      if (r >= 18'(RING_DEPTH << k)) begin
        r = r - 18'(RING_DEPTH << k);
      end
    end
    return AW'(r);
  endfunction

  function automatic logic signed [LP_W-1:0] wide_sat(input logic signed [ACC_W-1:0] v);
    if (v > WIDE_MAX) begin
      return LP_W'(WIDE_MAX);
    end else if (v < WIDE_MIN) begin
      return LP_W'(WIDE_MIN);
    end
    return LP_W'(v);
  endfunction

  function automatic logic signed [SB-1:0] smp_sat(input logic signed [ACC_W-1:0] v);
    if (v > SMP_MAX) begin
      return SB'(SMP_MAX);
    end else if (v < SMP_MIN) begin
      return SB'(SMP_MIN);
    end
    return SB'(v);
  endfunction

  // Control and configuration state
  logic [ST_W-1:0]                 state_q, state_d;
  logic                            ch_q, ch_d;
  logic [smr_pkg::TAP_IW-1:0]      tap_q, tap_d;
  logic [AW-1:0]                   wp_q, wp_d;
  logic [FILL_W-1:0]               fill_q, fill_d;
  logic [smr_pkg::CFG_DW-1:0]      cfg_delays_q, cfg_delays_d;
  logic [smr_pkg::CFG_DW-1:0]      cfg_gains_q, cfg_gains_d;
  logic [smr_pkg::COEF_W-1:0]      cfg_alpha_q, cfg_alpha_d;
  logic [smr_pkg::DAMP_W-1:0]      cfg_damp_q, cfg_damp_d;
  logic [smr_pkg::COEF_W-1:0]      cfg_decay_q, cfg_decay_d;
  logic [smr_pkg::COEF_W-1:0]      cfg_mix_q, cfg_mix_d;
  logic [smr_pkg::COEF_W-1:0]      cfg_target_q, cfg_target_d;
  logic [smr_pkg::COEF_W-1:0]      cfg_smooth_q, cfg_smooth_d;
  logic [smr_pkg::COEF_W-1:0]      lvl_q, lvl_d;
  logic signed [LP_W-1:0]          lp_q [2];
  logic signed [LP_W-1:0]          lp_d [2];
  logic signed [LP_W-1:0]          dp_q [2];
  logic signed [LP_W-1:0]          dp_d [2];
  logic                            out_valid_q, out_valid_d;

  // Datapath registers
  smr_pkg::out_t                   out_q, out_d;
  logic signed [SB-1:0]            xl_q, xl_d, xr_q, xr_d, yl_q, yl_d;
  logic signed [PROD_W-1:0]        prod_q, prod_d, cacc_q, cacc_d;
  logic signed [ERA_W-1:0]         acc_l_q, acc_l_d, acc_r_q, acc_r_d;
  logic signed [WET_W-1:0]         wet_q, wet_d;
  logic signed [MIX_W-1:0]         mix_q, mix_d;
  logic                            tap_ok_q, tap_ok_d;

  // Ring store and tap address
  logic                            in_accept;
  logic                            ram_re;
  logic [AW-1:0]                   ram_raddr;
  logic [2*SB-1:0]                 ram_rdata;
  logic [smr_pkg::TAP_IW-1:0]      iss_idx;
  logic [AW-1:0]                   dmod;

  // Shared multiplier
  logic signed [MA_W-1:0]          mul_a;
  logic signed [MB_W-1:0]          mul_b;
  logic signed [PROD_W-1:0]        mult_res;

  // Per-channel views and helpers
  logic signed [SB-1:0]            x_c, smp_l, smp_r, y_c;
  logic signed [ER_W-1:0]          er_c;
  logic signed [LP_W-1:0]          lp_c, dp_c;
  logic signed [MB_W-1:0]          lvl_diff;
  logic [smr_pkg::COEF_W-1:0]      damp_inv;
  logic [MB_W-1:0]                 mix_inv;
  logic [smr_pkg::TAP_FW-1:0]      gain_c;
  logic signed [ACC_W-1:0]         sum_a, sum_b;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_accept   = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Tap read issue: tap 0 in the level update, next tap on each right step but the last
  assign iss_idx = (state_q == ST_LVL_UPD) ? '0 : tap_q + smr_pkg::TAP_IW'(1);
  assign dmod    = ring_mod(cfg_delays_q[{iss_idx, 4'b0000} +: smr_pkg::TAP_FW]);
  assign ram_re  = (state_q == ST_LVL_UPD) || ((state_q == ST_TAP_R) && (tap_q != TAP_LAST));
  assign ram_raddr = (wp_q >= dmod) ? wp_q - dmod
                   : AW'((AW+1)'(wp_q) + (AW+1)'(RING_DEPTH) - (AW+1)'(dmod));

  smr_ram #(
    .WIDTH (2 * SB),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (in_accept),
    .waddr_i (wp_q),
    .wdata_i ({in_data_i.in_right, in_data_i.in_left}),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Entries never written read as zero
  assign smp_l  = tap_ok_q ? $signed(ram_rdata[SB-1:0]) : '0;
  assign smp_r  = tap_ok_q ? $signed(ram_rdata[2*SB-1:SB]) : '0;
  assign gain_c = cfg_gains_q[{tap_q, 4'b0000} +: smr_pkg::TAP_FW];

  assign x_c  = ch_q ? xr_q : xl_q;
  assign lp_c = lp_q[ch_q];
  assign dp_c = dp_q[ch_q];
  assign er_c = ER_W'((ch_q ? acc_r_q : acc_l_q) >>> 16);

  assign lvl_diff = $signed({1'b0, cfg_target_q}) - $signed({1'b0, lvl_q});
  assign damp_inv = smr_pkg::COEF_W'(smr_pkg::ONE_Q16) - {1'b0, cfg_damp_q};
  assign mix_inv  = MB_W'(smr_pkg::ONE_Q16) - {1'b0, cfg_mix_q};

  assign mult_res = PROD_W'(mul_a) * PROD_W'(mul_b);

  always_comb begin
    state_d      = state_q;
    ch_d         = ch_q;
    tap_d        = tap_q;
    wp_d         = wp_q;
    fill_d       = fill_q;
    cfg_delays_d = cfg_delays_q;
    cfg_gains_d  = cfg_gains_q;
    cfg_alpha_d  = cfg_alpha_q;
    cfg_damp_d   = cfg_damp_q;
    cfg_decay_d  = cfg_decay_q;
    cfg_mix_d    = cfg_mix_q;
    cfg_target_d = cfg_target_q;
    cfg_smooth_d = cfg_smooth_q;
    lvl_d        = lvl_q;
    lp_d         = lp_q;
    dp_d         = dp_q;
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    xl_d         = xl_q;
    xr_d         = xr_q;
    yl_d         = yl_q;
    prod_d       = prod_q;
    cacc_d       = cacc_q;
    acc_l_d      = acc_l_q;
    acc_r_d      = acc_r_q;
    wet_d        = wet_q;
    mix_d        = mix_q;
    tap_ok_d     = tap_ok_q;
    mul_a        = '0;
    mul_b        = '0;
    sum_a        = '0;
    sum_b        = '0;
    y_c          = '0;

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        smr_pkg::REG_TAP_DELAYS:    cfg_delays_d = cfg_data_i;
        smr_pkg::REG_TAP_GAINS:     cfg_gains_d  = cfg_data_i;
        smr_pkg::REG_FILTER_ALPHA:  cfg_alpha_d  = cfg_data_i[smr_pkg::COEF_W-1:0];
        smr_pkg::REG_DAMP_COEF:     cfg_damp_d   = cfg_data_i[smr_pkg::DAMP_W-1:0];
        smr_pkg::REG_DECAY_GAIN:    cfg_decay_d  = cfg_data_i[smr_pkg::COEF_W-1:0];
        smr_pkg::REG_MIX_GAIN:      cfg_mix_d    = cfg_data_i[smr_pkg::COEF_W-1:0];
        smr_pkg::REG_BYPASS_TARGET: cfg_target_d = cfg_data_i[smr_pkg::COEF_W-1:0];
        smr_pkg::REG_BYPASS_SMOOTH: cfg_smooth_d = cfg_data_i[smr_pkg::COEF_W-1:0];
        default: ;
      endcase
    end

    if (ram_re) begin
      tap_ok_d = FILL_W'(dmod) < fill_q;
    end

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          xl_d    = in_data_i.in_left;
          xr_d    = in_data_i.in_right;
          fill_d  = (fill_q == FILL_W'(RING_DEPTH)) ? fill_q : fill_q + FILL_W'(1);
          state_d = ST_LVL_MUL;
        end
      end
      ST_LVL_MUL: begin
        mul_a   = MA_W'(lvl_diff);
        mul_b   = $signed({1'b0, cfg_smooth_q});
        prod_d  = mult_res;
        state_d = ST_LVL_UPD;
      end
      ST_LVL_UPD: begin
        sum_a = ACC_W'($signed({1'b0, lvl_q})) + ACC_W'(prod_q >>> 16);
        if (sum_a < 0) begin
          lvl_d = '0;
        end else if (sum_a > LVL_MAX) begin
          lvl_d = smr_pkg::COEF_W'(LVL_MAX);
        end else begin
          lvl_d = smr_pkg::COEF_W'(sum_a);
        end
        acc_l_d = '0;
        acc_r_d = '0;
        tap_d   = '0;
        state_d = ST_TAP_L;
      end
      ST_TAP_L: begin
        mul_a  = MA_W'(smp_l);
        mul_b  = $signed({2'b00, gain_c});
        prod_d = mult_res;
        if (tap_q != '0) begin
          acc_r_d = acc_r_q + ERA_W'(prod_q);
        end
        state_d = ST_TAP_R;
      end
      ST_TAP_R: begin
        acc_l_d = acc_l_q + ERA_W'(prod_q);
        mul_a   = MA_W'(smp_r);
        mul_b   = $signed({2'b00, gain_c});
        prod_d  = mult_res;
        if (tap_q == TAP_LAST) begin
          state_d = ST_TAP_END;
        end else begin
          tap_d   = tap_q + smr_pkg::TAP_IW'(1);
          state_d = ST_TAP_L;
        end
      end
      ST_TAP_END: begin
        acc_r_d = acc_r_q + ERA_W'(prod_q);
        wp_d    = (wp_q == AW'(RING_DEPTH - 1)) ? '0 : wp_q + AW'(1);
        ch_d    = 1'b0;
        state_d = ST_LP_MUL;
      end
      ST_LP_MUL: begin
        mul_a   = MA_W'(er_c) - MA_W'(lp_c);
        mul_b   = $signed({1'b0, cfg_alpha_q});
        prod_d  = mult_res;
        state_d = ST_LP_UPD;
      end
      ST_LP_UPD: begin
        sum_a       = ACC_W'(lp_c) + ACC_W'(prod_q >>> 16);
        lp_d[ch_q]  = wide_sat(sum_a);
        state_d     = ST_DP_MUL1;
      end
      ST_DP_MUL1: begin
        mul_a   = MA_W'(lp_c);
        mul_b   = $signed({1'b0, damp_inv});
        prod_d  = mult_res;
        state_d = ST_DP_MUL2;
      end
      ST_DP_MUL2: begin
        cacc_d  = prod_q;
        mul_a   = MA_W'(dp_c);
        mul_b   = $signed({2'b00, cfg_damp_q});
        prod_d  = mult_res;
        state_d = ST_DP_UPD;
      end
      ST_DP_UPD: begin
        sum_a      = ACC_W'(cacc_q) + ACC_W'(prod_q);
        sum_b      = sum_a >>> 16;
        dp_d[ch_q] = wide_sat(sum_b);
        state_d    = ST_DEC_MUL;
      end
      ST_DEC_MUL: begin
        mul_a   = MA_W'(dp_c);
        mul_b   = $signed({1'b0, cfg_decay_q});
        prod_d  = mult_res;
        state_d = ST_WET;
      end
      ST_WET: begin
        sum_a   = ACC_W'(er_c) + ACC_W'(prod_q >>> 16);
        wet_d   = WET_W'(sum_a);
        mul_a   = MA_W'(x_c);
        mul_b   = $signed(mix_inv);
        prod_d  = mult_res;
        state_d = ST_MIX_MUL;
      end
      ST_MIX_MUL: begin
        cacc_d  = prod_q;
        mul_a   = MA_W'(wet_q);
        mul_b   = $signed({1'b0, cfg_mix_q});
        prod_d  = mult_res;
        state_d = ST_MIX_UPD;
      end
      ST_MIX_UPD: begin
        sum_a   = ACC_W'(cacc_q) + ACC_W'(prod_q);
        sum_b   = sum_a >>> 16;
        mix_d   = MIX_W'(sum_b);
        state_d = ST_BYP_MUL;
      end
      ST_BYP_MUL: begin
        mul_a   = MA_W'(x_c) - MA_W'(mix_q);
        mul_b   = $signed({1'b0, lvl_q});
        prod_d  = mult_res;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        sum_a = ACC_W'(mix_q) + ACC_W'(prod_q >>> 16);
        y_c   = smp_sat(sum_a);
        if (!ch_q) begin
          yl_d    = y_c;
          ch_d    = 1'b1;
          state_d = ST_LP_MUL;
        end else if (!out_valid_q || out_ready_i) begin
          out_d.out_left  = yl_q;
          out_d.out_right = y_c;
          out_valid_d     = 1'b1;
          ch_d            = 1'b0;
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      ch_q         <= 1'b0;
      tap_q        <= '0;
      wp_q         <= '0;
      fill_q       <= '0;
      cfg_delays_q <= '0;
      cfg_gains_q  <= '0;
      cfg_alpha_q  <= smr_pkg::RST_ALPHA;
      cfg_damp_q   <= smr_pkg::RST_DAMP;
      cfg_decay_q  <= smr_pkg::RST_DECAY;
      cfg_mix_q    <= smr_pkg::RST_MIX;
      cfg_target_q <= smr_pkg::RST_TARGET;
      cfg_smooth_q <= smr_pkg::RST_SMOOTH;
      lvl_q        <= '0;
      lp_q[0]      <= '0;
      lp_q[1]      <= '0;
      dp_q[0]      <= '0;
      dp_q[1]      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      ch_q         <= ch_d;
      tap_q        <= tap_d;
      wp_q         <= wp_d;
      fill_q       <= fill_d;
      cfg_delays_q <= cfg_delays_d;
      cfg_gains_q  <= cfg_gains_d;
      cfg_alpha_q  <= cfg_alpha_d;
      cfg_damp_q   <= cfg_damp_d;
      cfg_decay_q  <= cfg_decay_d;
      cfg_mix_q    <= cfg_mix_d;
      cfg_target_q <= cfg_target_d;
      cfg_smooth_q <= cfg_smooth_d;
      lvl_q        <= lvl_d;
      lp_q         <= lp_d;
      dp_q         <= dp_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q    <= out_d;
    xl_q     <= xl_d;
    xr_q     <= xr_d;
    yl_q     <= yl_d;
    prod_q   <= prod_d;
    cacc_q   <= cacc_d;
    acc_l_q  <= acc_l_d;
    acc_r_q  <= acc_r_d;
    wet_q    <= wet_d;
    mix_q    <= mix_d;
    tap_ok_q <= tap_ok_d;
  end

  // Checks
  `SMR_ASSERT_HOLD(a_fill_bound, fill_q <= FILL_W'(RING_DEPTH), "fill count past ring depth")
  `SMR_ASSERT_HOLD(a_wp_bound, int'(wp_q) < RING_DEPTH, "write pointer outside ring")
  `SMR_ASSERT_NXT(a_accept_starts, in_accept, state_q == ST_LVL_MUL, "request did not start")
  `SMR_ASSERT_IMP(a_out_from_last, $rose(out_valid_q), ($past(state_q) == ST_OUT) && $past(ch_q), "result raised outside right-channel output step")

endmodule

// ===== tb/stereo_multitap_reverb_tb.sv =====
// Self-checking testbench for the stereo multitap early-reflection reverb.
`timescale 1ns / 100ps

module stereo_multitap_reverb_tb;

  // Saturation bounds of the filter states and of the output samples
  localparam longint STATE_LIM = longint'(1) << (smr_pkg::SAMPLE_BITS + 2);
  localparam longint PEAK_POS  = (longint'(1) << (smr_pkg::SAMPLE_BITS - 1)) - 1;
  localparam longint PEAK_NEG  = -(longint'(1) << (smr_pkg::SAMPLE_BITS - 1));
  localparam int     RING_LEN  = 65536;

  logic                       clk       = 1'b0;
  logic                       rst_n     = 1'b0;
  logic                       in_valid  = 1'b0;
  logic                       in_ready;
  smr_pkg::in_t               in_data   = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  smr_pkg::out_t              out_data;
  logic                       cfg_we    = 1'b0;
  logic [smr_pkg::CFG_IW-1:0] cfg_idx   = '0;
  logic [smr_pkg::CFG_DW-1:0] cfg_data  = '0;

  stereo_multitap_reverb i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Shadow copy of the register file, updated as each write is issued
  logic [63:0] delays_cfg = '0;
  logic [63:0] gains_cfg  = '0;
  longint      alpha_cfg  = longint'(smr_pkg::RST_ALPHA);
  longint      damp_cfg   = longint'(smr_pkg::RST_DAMP);
  longint      decay_cfg  = longint'(smr_pkg::RST_DECAY);
  longint      mix_cfg    = longint'(smr_pkg::RST_MIX);
  longint      target_cfg = longint'(smr_pkg::RST_TARGET);
  longint      smooth_cfg = longint'(smr_pkg::RST_SMOOTH);

  // Predicted block state: ring stores start cleared, as the fill count implies
  int          ring_mem [2][RING_LEN];
  logic [15:0] wr_ptr = '0;
  longint      lp_st [2];
  longint      dp_st [2];
  longint      bypass_lvl = 0;

  smr_pkg::in_t  pairs_to_send [$];   // requests waiting for the driver
  smr_pkg::out_t pairs_due [$];       // predicted outputs, oldest first
  int            n_queued = 0;
  int            n_taken  = 0;
  int            n_bad    = 0;
  int            n_seen   = 0;
  bit            calm     = 1'b0;     // no idling on either side while set
  smr_pkg::out_t want;

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // One sample period of the reverb: updates the predicted state, returns the output pair.
  // All shifts are arithmetic, so they floor like the block does.
  function automatic smr_pkg::out_t reverb_step(smr_pkg::in_t x);
    longint        dry [2];
    longint        er;
    longint        wet;
    longint        mixed;
    longint        blend;
    logic [15:0]   rd_ptr;
    logic [23:0]   res [2];
    smr_pkg::out_t y;
    dry[0] = longint'($signed(x.in_left));
    dry[1] = longint'($signed(x.in_right));
    // Level moves toward the target only by smoothing, whatever the target did
    bypass_lvl = clip(bypass_lvl + (((target_cfg - bypass_lvl) * smooth_cfg) >>> 16),
                      0, longint'(smr_pkg::LEVEL_MAX));
    for (int c = 0; c < 2; c++) begin
      // Written first, so a zero delay reads this very sample
      ring_mem[c][wr_ptr] = int'(dry[c]);
      er = 0;
      for (int t = 0; t < smr_pkg::TAP_FIELDS; t++) begin
        rd_ptr = wr_ptr - delays_cfg[smr_pkg::TAP_FW*t +: smr_pkg::TAP_FW];
        er += longint'(ring_mem[c][rd_ptr]) *
              longint'(gains_cfg[smr_pkg::TAP_FW*t +: smr_pkg::TAP_FW]);
      end
      er = er >>> 16;
      lp_st[c] = clip(lp_st[c] + (((er - lp_st[c]) * alpha_cfg) >>> 16),
                      -STATE_LIM, STATE_LIM - 1);
      dp_st[c] = clip((lp_st[c] * (longint'(smr_pkg::ONE_Q16) - damp_cfg) +
                       dp_st[c] * damp_cfg) >>> 16,
                      -STATE_LIM, STATE_LIM - 1);
      wet   = er + ((dp_st[c] * decay_cfg) >>> 16);
      mixed = (dry[c] * (longint'(smr_pkg::ONE_Q16) - mix_cfg) + wet * mix_cfg) >>> 16;
      blend = clip(mixed + (((dry[c] - mixed) * bypass_lvl) >>> 16), PEAK_NEG, PEAK_POS);
      res[c] = blend[23:0];
    end
    wr_ptr = wr_ptr + 16'd1;
    y.out_left  = res[0];
    y.out_right = res[1];
    return y;
  endfunction

  function automatic bit skip_cycle();
    return !calm && ($urandom_range(99) < 29);
  endfunction

  function automatic logic [23:0] extreme(logic [1:0] sel);
    case (sel)
      2'd0:    return 24'h7FFFFF;
      2'd1:    return 24'h800000;
      2'd2:    return 24'h000000;
      default: return 24'hFFFFFF;
    endcase
  endfunction

  function automatic smr_pkg::in_t rand_pair();
    logic [31:0]  a;
    logic [31:0]  b;
    smr_pkg::in_t p;
    a = $urandom;
    b = $urandom;
    case ($urandom_range(9))
      0: begin
        p.in_left  = extreme(a[1:0]);
        p.in_right = extreme(b[1:0]);
      end
      1: begin
        // quiet passage, keeps the filters out of saturation
        p.in_left  = {{13{a[10]}}, a[10:0]};
        p.in_right = {{13{b[10]}}, b[10:0]};
      end
      default: p = {a[23:0], b[23:0]};
    endcase
    return p;
  endfunction

  function automatic logic [63:0] rand_coef(logic [63:0] one_val);
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(7))
      0:       return 64'd0;
      1:       return one_val;
      2:       return r;          // high bits beyond the register must be dropped
      3:       return 64'd131071;
      default: return {47'd0, r[16:0]} % (one_val + 64'd1);
    endcase
  endfunction

  function automatic logic [63:0] rand_delays();
    logic [63:0] v;
    logic [31:0] r;
    logic [31:0] near;
    for (int t = 0; t < smr_pkg::TAP_FIELDS; t++) begin
      r    = $urandom;
      near = $urandom_range(1, 400);
      case (r[2:0])
        3'd0:    v[smr_pkg::TAP_FW*t +: smr_pkg::TAP_FW] = 16'd0;
        3'd1:    v[smr_pkg::TAP_FW*t +: smr_pkg::TAP_FW] = 16'hFFFF;
        3'd2:    v[smr_pkg::TAP_FW*t +: smr_pkg::TAP_FW] = r[31:16];
        default: v[smr_pkg::TAP_FW*t +: smr_pkg::TAP_FW] = near[15:0];
      endcase
    end
    return v;
  endfunction

  function automatic logic [63:0] rand_gains();
    logic [63:0] v;
    logic [31:0] r;
    for (int t = 0; t < smr_pkg::TAP_FIELDS; t++) begin
      r = $urandom;
      case (r[1:0])
        2'd0:    v[smr_pkg::TAP_FW*t +: smr_pkg::TAP_FW] = 16'd0;
        2'd1:    v[smr_pkg::TAP_FW*t +: smr_pkg::TAP_FW] = 16'hFFFF;
        default: v[smr_pkg::TAP_FW*t +: smr_pkg::TAP_FW] = r[31:16];
      endcase
    end
    return v;
  endfunction

  // Register write; the shadow keeps only the register's own width
  task automatic write_reg(logic [smr_pkg::CFG_IW-1:0] idx, logic [63:0] val);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    case (idx)
      smr_pkg::REG_TAP_DELAYS:    delays_cfg = val;
      smr_pkg::REG_TAP_GAINS:     gains_cfg  = val;
      smr_pkg::REG_FILTER_ALPHA:  alpha_cfg  = longint'(val[16:0]);
      smr_pkg::REG_DAMP_COEF:     damp_cfg   = longint'(val[15:0]);
      smr_pkg::REG_DECAY_GAIN:    decay_cfg  = longint'(val[16:0]);
      smr_pkg::REG_MIX_GAIN:      mix_cfg    = longint'(val[16:0]);
      smr_pkg::REG_BYPASS_TARGET: target_cfg = longint'(val[16:0]);
      default:                    smooth_cfg = longint'(val[16:0]);
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send(smr_pkg::in_t p);
    pairs_to_send.insert(pairs_to_send.size(), p);
    n_queued = n_queued + 1;
  endtask

  // Wait until every request is taken and answered, then let the pipe go quiet
  task automatic settle(int tail);
    while (n_taken != n_queued || pairs_due.size() != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  task automatic check_field(string name, logic [23:0] exp_v, logic [23:0] got_v);
    if (exp_v !== got_v) begin
      n_bad = n_bad + 1;
      if (n_bad <= 10)
        $display("%0t ns: result %0d %s mismatch: expected %h, got %h",
                 $time, n_seen, name, exp_v, got_v);
    end
  endtask

  // Driver: a request holds until accepted; prediction happens on the accepting edge
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
    end else begin
      if (in_valid && in_ready) begin
        pairs_due.insert(pairs_due.size(), reverb_step(in_data));
        n_taken = n_taken + 1;
      end
      if (!in_valid || in_ready) begin
        if (pairs_to_send.size() != 0 && !skip_cycle()) begin
          in_valid <= 1'b1;
          in_data  <= pairs_to_send.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random back-pressure, each accepted pair checked against the oldest prediction
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pairs_due.size() == 0) begin
          n_bad = n_bad + 1;
          if (n_bad <= 10)
            $display("%0t ns: output pair %h with nothing outstanding", $time, out_data);
        end else begin
          want = pairs_due.pop_front();
          check_field("out_left", want.out_left, out_data.out_left);
          check_field("out_right", want.out_right, out_data.out_right);
        end
        n_seen = n_seen + 1;
      end
      out_ready <= !skip_cycle();
    end
  end

  initial begin : stimulus
    smr_pkg::in_t p;
    int           sent;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: taps silent, output is the dry path through the mix
    for (int k = 0; k < 4; k++) begin
      p.in_left  = extreme(k[1:0]);
      p.in_right = extreme(~k[1:0]);
      send(p);
    end
    send({24'h555555, 24'hAAAAAA});
    settle(4);

    // Everything at the top: coefficients above one (damping just below), longest delay,
    // high gains, bypass level driven to its ceiling; the alpha write carries junk high bits
    write_reg(smr_pkg::REG_TAP_DELAYS, 64'hFFFF_0003_0001_0000);
    write_reg(smr_pkg::REG_TAP_GAINS, 64'hFFFF_8000_4000_FFFF);
    write_reg(smr_pkg::REG_FILTER_ALPHA, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(smr_pkg::REG_DAMP_COEF, 64'h0000_0000_0000_FFFF);
    write_reg(smr_pkg::REG_DECAY_GAIN, 64'h0000_0000_0001_FFFF);
    write_reg(smr_pkg::REG_MIX_GAIN, 64'h0000_0000_0001_FFFF);
    write_reg(smr_pkg::REG_BYPASS_TARGET, 64'h0000_0000_0001_FFFF);
    write_reg(smr_pkg::REG_BYPASS_SMOOTH, 64'h0000_0000_0001_FFFF);
    repeat (4) send({24'h7FFFFF, 24'h800000});
    repeat (4) send({24'h800000, 24'h7FFFFF});
    send({24'h555555, 24'hAAAAAA});
    send({24'hAAAAAA, 24'h555555});
    send({24'hFFFFFF, 24'h000000});
    send({24'h7FFFFF, 24'h7FFFFF});
    settle(4);

    // Fully wet, filters off, four zero-delay taps on the current sample:
    // output overflows; target drops to zero and the level follows in one step
    write_reg(smr_pkg::REG_TAP_DELAYS, 64'd0);
    write_reg(smr_pkg::REG_TAP_GAINS, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(smr_pkg::REG_FILTER_ALPHA, 64'd0);
    write_reg(smr_pkg::REG_DAMP_COEF, 64'd0);
    write_reg(smr_pkg::REG_DECAY_GAIN, 64'd0);
    write_reg(smr_pkg::REG_MIX_GAIN, 64'd65536);
    write_reg(smr_pkg::REG_BYPASS_TARGET, 64'd0);
    write_reg(smr_pkg::REG_BYPASS_SMOOTH, 64'd65536);
    send({24'h7FFFFF, 24'h800000});
    send({24'h800000, 24'h7FFFFF});
    send({24'hFFFFFF, 24'h000001});
    send({24'h000000, 24'h000000});
    send({24'h100000, 24'hF00000});
    settle(4);

    // Random settings, ten passes; one pass runs without any idling
    for (int ph = 0; ph < 10; ph++) begin
      write_reg(smr_pkg::REG_TAP_DELAYS, rand_delays());
      write_reg(smr_pkg::REG_TAP_GAINS, rand_gains());
      write_reg(smr_pkg::REG_FILTER_ALPHA, rand_coef(64'd65536));
      write_reg(smr_pkg::REG_DAMP_COEF, rand_coef(64'd52429));
      write_reg(smr_pkg::REG_DECAY_GAIN, rand_coef(64'd65536));
      write_reg(smr_pkg::REG_MIX_GAIN, rand_coef(64'd65536));
      write_reg(smr_pkg::REG_BYPASS_TARGET, rand_coef(64'd65536));
      write_reg(smr_pkg::REG_BYPASS_SMOOTH, rand_coef(64'd65536));
      calm = (ph == 4);
      sent = 0;
      while (sent < 150) begin
        if ($urandom_range(15) == 0) begin
          // sustained burst of extreme samples to push the filter states into saturation
          p = rand_pair();
          p.in_left  = extreme(p.in_left[1:0]);
          p.in_right = extreme(p.in_right[1:0]);
          repeat (12) send(p);
          sent = sent + 12;
        end else begin
          send(rand_pair());
          sent = sent + 1;
        end
      end
      settle(4);
      calm = 1'b0;
    end

    settle(40);
    if (n_bad == 0 && pairs_due.size() == 0) begin
      $display("stereo_multitap_reverb verification clean");
    end else begin
      $display("stereo_multitap_reverb verification failed");
    end
    $finish;
  end

  // Watchdog: a run that hangs is stopped and reported as failed
  initial begin : watchdog
    #8000000;
    $display("stereo_multitap_reverb verification failed");
    $finish;
  end

endmodule
